### rtl/ck_pkg.sv
`default_nettype none

package ck_pkg;

    typedef struct packed {
        logic [7:0] bg_blue;
        logic [7:0] bg_green;
        logic [7:0] bg_red;
        logic [7:0] fg_blue;
        logic [7:0] fg_green;
        logic [7:0] fg_red;
    } px_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } key_t;

    typedef enum logic [2:0] {
        REG_KEY_RED   = 3'd0,
        REG_KEY_GREEN = 3'd1,
        REG_KEY_BLUE  = 3'd2,
        REG_TOL_LOW   = 3'd3,
        REG_TOL_HIGH  = 3'd4
    } reg_idx_t;

    localparam int SQ_W    = 26;
    localparam int DIST_W  = 13;
    localparam int TOL_W   = 9;
    localparam int SQRT_N  = 13;

    localparam logic signed [26:0] C_OFS    = 27'sd8421376;
    localparam logic signed [26:0] C_CB_R   = 27'sd11058;
    localparam logic signed [26:0] C_CB_G   = 27'sd21710;
    localparam logic signed [26:0] C_HALF   = 27'sd32768;
    localparam logic signed [26:0] C_CR_G   = 27'sd27439;
    localparam logic signed [26:0] C_CR_B   = 27'sd5329;

endpackage

`default_nettype wire

### rtl/ck_color.sv
`default_nettype none

module ck_color (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire logic            in_valid,
    input  wire ck_pkg::px_t     in_px,
    input  wire ck_pkg::key_t    key,
    output logic                 out_valid,
    output ck_pkg::px_t          out_px,
    output logic [ck_pkg::SQ_W-1:0] out_sq
);

    function automatic logic [8:0] cb_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
        logic signed [26:0] acc;
        acc = ck_pkg::C_OFS - ck_pkg::C_CB_R * $signed({19'd0, r})
            - ck_pkg::C_CB_G * $signed({19'd0, g}) + ck_pkg::C_HALF * $signed({19'd0, b});
        return acc[24:16];
    endfunction

    function automatic logic [8:0] cr_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
        logic signed [26:0] acc;
        acc = ck_pkg::C_OFS + ck_pkg::C_HALF * $signed({19'd0, r})
            - ck_pkg::C_CR_G * $signed({19'd0, g}) - ck_pkg::C_CR_B * $signed({19'd0, b});
        return acc[24:16];
    endfunction

    logic signed [9:0]  dcb_next, dcr_next, dcb_reg, dcr_reg;
    logic               v1_reg, v2_reg;
    ck_pkg::px_t        px1_reg, px2_reg;
    logic [19:0]        cb2, cr2;
    logic [20:0]        sum_sq;
    logic [ck_pkg::SQ_W-1:0] sq_next, sq_reg;

    assign dcb_next = $signed({1'b0, cb_of(key.red, key.green, key.blue)})
                    - $signed({1'b0, cb_of(in_px.fg_red, in_px.fg_green, in_px.fg_blue)});
    assign dcr_next = $signed({1'b0, cr_of(key.red, key.green, key.blue)})
                    - $signed({1'b0, cr_of(in_px.fg_red, in_px.fg_green, in_px.fg_blue)});

    assign cb2     = 20'(dcb_reg * dcb_reg);
    assign cr2     = 20'(dcr_reg * dcr_reg);
    assign sum_sq  = {1'b0, cb2} + {1'b0, cr2};
    assign sq_next = {sum_sq[17:0], 8'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dcb_reg <= dcb_next;
            dcr_reg <= dcr_next;
            px1_reg <= in_px;
            sq_reg  <= sq_next;
            px2_reg <= px1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_px    = px2_reg;
    assign out_sq    = sq_reg;

endmodule

`default_nettype wire

### rtl/ck_sqrt.sv
`default_nettype none

module ck_sqrt (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   adv,
    input  wire logic                   in_valid,
    input  wire ck_pkg::px_t            in_px,
    input  wire logic [ck_pkg::SQ_W-1:0] in_sq,
    output logic                        out_valid,
    output ck_pkg::px_t                 out_px,
    output logic [ck_pkg::DIST_W-1:0]   out_dist
);

    localparam int N = ck_pkg::SQRT_N;
    localparam int W = ck_pkg::SQ_W;

    logic [W-1:0]  v_in   [N];
    logic [W-1:0]  res_in [N];
    logic [W-1:0]  v_reg  [N];
    logic [W-1:0]  res_reg[N];
    logic          vld_reg[N];
    ck_pkg::px_t   px_reg [N];

    assign v_in[0]   = in_sq;
    assign res_in[0] = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_step
        localparam logic [W:0] BITV = (W+1)'(1) << (2 * (N - 1 - i));
        logic [W:0]   trial;
        logic         take;
        logic [W-1:0] v_next, res_next;

        if (i > 0)
        begin : g_link
            assign v_in[i]   = v_reg[i-1];
            assign res_in[i] = res_reg[i-1];
        end

        assign trial    = {1'b0, res_in[i]} + BITV;
        assign take     = {1'b0, v_in[i]} >= trial;
        assign v_next   = take ? v_in[i] - trial[W-1:0] : v_in[i];
        assign res_next = take ? (res_in[i] >> 1) + BITV[W-1:0] : res_in[i] >> 1;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (adv)
                vld_reg[i] <= (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                v_reg[i]   <= v_next;
                res_reg[i] <= res_next;
                px_reg[i]  <= (i == 0) ? in_px : px_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_px    = px_reg[N-1];
    assign out_dist  = res_reg[N-1][ck_pkg::DIST_W-1:0];

endmodule

`default_nettype wire

### rtl/ck_div.sv
`default_nettype none

module ck_div #(
    parameter int MASK_BITS = 8
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     adv,
    input  wire logic                     in_valid,
    input  wire ck_pkg::px_t              in_px,
    input  wire logic [ck_pkg::DIST_W-1:0] in_dist,
    input  wire logic [ck_pkg::TOL_W-1:0]  tol_low,
    input  wire logic [ck_pkg::TOL_W-1:0]  tol_high,
    output logic                          out_valid,
    output ck_pkg::px_t                   out_px,
    output logic                          out_below,
    output logic                          out_ramp,
    output logic [MASK_BITS:0]            out_quot
);

    localparam int DW = ck_pkg::DIST_W;
    localparam int NW = MASK_BITS + DW + 2;
    localparam int DS = MASK_BITS + 1;

    logic [DW-1:0] lo, hi, span, diff;
    logic          below_next, ramp_next;
    logic [NW-1:0] num_next;

    logic          e_vld_reg, e_below_reg, e_ramp_reg;
    logic [NW-1:0] e_num_reg;
    logic [DW:0]   e_den_reg;
    ck_pkg::px_t   e_px_reg;

    logic [NW-1:0]      rem_in [DS];
    logic [MASK_BITS:0] q_in   [DS];
    logic [NW-1:0]      rem_reg[DS];
    logic [MASK_BITS:0] q_reg  [DS];
    logic [DW:0]        den_reg[DS];
    logic               vld_reg[DS];
    logic               blw_reg[DS];
    logic               rmp_reg[DS];
    ck_pkg::px_t        px_reg [DS];

    assign lo         = {tol_low, 4'd0};
    assign hi         = {tol_high, 4'd0};
    assign span       = hi - lo;
    assign diff       = in_dist - lo;
    assign below_next = in_dist < lo;
    assign ramp_next  = !below_next && (in_dist < hi);
    assign num_next   = {1'b0, diff, {(MASK_BITS+1){1'b0}}} + NW'(span);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else if (adv)
            e_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_below_reg <= below_next;
            e_ramp_reg  <= ramp_next;
            e_num_reg   <= num_next;
            e_den_reg   <= {span, 1'b0};
            e_px_reg    <= in_px;
        end
    end

    assign rem_in[0] = e_num_reg;
    assign q_in[0]   = '0;

    for (genvar j = 0; j < DS; j++)
    begin : g_bit
        localparam int SH = MASK_BITS - j;
        logic [NW-1:0]      dsh;
        logic               take;
        logic [DW:0]        den_in;
        logic               vld_in, blw_in, rmp_in;
        ck_pkg::px_t        px_in;

        if (j == 0)
        begin : g_first
            assign den_in = e_den_reg;
            assign vld_in = e_vld_reg;
            assign blw_in = e_below_reg;
            assign rmp_in = e_ramp_reg;
            assign px_in  = e_px_reg;
        end
        else
        begin : g_link
            assign rem_in[j] = rem_reg[j-1];
            assign q_in[j]   = q_reg[j-1];
            assign den_in    = den_reg[j-1];
            assign vld_in    = vld_reg[j-1];
            assign blw_in    = blw_reg[j-1];
            assign rmp_in    = rmp_reg[j-1];
            assign px_in     = px_reg[j-1];
        end

        assign dsh  = NW'(den_in) << SH;
        assign take = rem_in[j] >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (adv)
                vld_reg[j] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j] <= take ? rem_in[j] - dsh : rem_in[j];
                q_reg[j]   <= q_in[j] | ((MASK_BITS+1)'(take) << SH);
                den_reg[j] <= den_in;
                blw_reg[j] <= blw_in;
                rmp_reg[j] <= rmp_in;
                px_reg[j]  <= px_in;
            end
        end
    end

    assign out_valid = vld_reg[DS-1];
    assign out_px    = px_reg[DS-1];
    assign out_below = blw_reg[DS-1];
    assign out_ramp  = rmp_reg[DS-1];
    assign out_quot  = q_reg[DS-1];

endmodule

`default_nettype wire

### rtl/ck_blend.sv
`default_nettype none

module ck_blend #(
    parameter int MASK_BITS = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire ck_pkg::px_t   in_px,
    input  wire logic          in_below,
    input  wire logic          in_ramp,
    input  wire logic [MASK_BITS:0] in_quot,
    input  wire ck_pkg::key_t  key,
    output logic               out_valid,
    output logic [7:0]         out_red,
    output logic [7:0]         out_green,
    output logic [7:0]         out_blue
);

    localparam int PW = MASK_BITS + 9;
    localparam logic [MASK_BITS:0] FULL = (MASK_BITS+1)'(1) << MASK_BITS;

    logic [MASK_BITS:0] mask;
    logic [7:0]  fg_c[3], bg_c[3], key_c[3];
    logic [PW-1:0] mk_reg[3], mb_reg[3];
    logic [7:0]  fg_reg[3];
    logic [7:0]  res_next[3], res_reg[3];
    logic        a_vld_reg, b_vld_reg;

    assign mask = in_ramp ? FULL - in_quot : (in_below ? FULL : '0);

    assign fg_c[0]  = in_px.fg_red;
    assign fg_c[1]  = in_px.fg_green;
    assign fg_c[2]  = in_px.fg_blue;
    assign bg_c[0]  = in_px.bg_red;
    assign bg_c[1]  = in_px.bg_green;
    assign bg_c[2]  = in_px.bg_blue;
    assign key_c[0] = key.red;
    assign key_c[1] = key.green;
    assign key_c[2] = key.blue;

    for (genvar c = 0; c < 3; c++)
    begin : g_ch
        logic [PW-1:0] fgs, fore;
        logic [PW:0]   sum;
        logic [PW-MASK_BITS:0] scaled;

        assign fgs    = PW'({fg_reg[c], {MASK_BITS{1'b0}}});
        assign fore   = (mk_reg[c] > fgs) ? '0 : fgs - mk_reg[c];
        assign sum    = {1'b0, fore} + {1'b0, mb_reg[c]};
        assign scaled = sum[PW:MASK_BITS];
        assign res_next[c] = (scaled > (PW-MASK_BITS+1)'(255)) ? 8'hFF : scaled[7:0];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                mk_reg[c]  <= PW'(mask * key_c[c]);
                mb_reg[c]  <= PW'(mask * bg_c[c]);
                fg_reg[c]  <= fg_c[c];
                res_reg[c] <= res_next[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
        end
    end

    assign out_valid = b_vld_reg;
    assign out_red   = res_reg[0];
    assign out_green = res_reg[1];
    assign out_blue  = res_reg[2];

endmodule

`default_nettype wire

### rtl/chroma_key_composite.sv
// Chroma-key compositor: one foreground/background RGB pixel pair in per clock, one
// composited pixel out per clock. The foreground chroma distance to the key colour sets
// a soft mask (MASK_BITS fraction bits) that blends background in over the keyed
// foreground. The pipeline runs color conversion and squaring, the one-bit-per-stage
// square root, the restoring mask divider and blending, in that order. Throughput is
// one item per cycle; the whole pipeline holds when the output item is not taken.
// Write registers over APB only while no items are in flight.

`default_nettype none

module chroma_key_composite #(
    parameter int MASK_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_red, out_green, out_blue
    output logic [23:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0] key_red_reg, key_green_reg, key_blue_reg;
    logic [ck_pkg::TOL_W-1:0] tol_low_reg, tol_high_reg;
    ck_pkg::reg_idx_t idx;
    logic wr;
    logic adv;
    ck_pkg::key_t key;
    ck_pkg::px_t  in_px, c_px, s_px, d_px;
    logic c_vld, s_vld, d_vld, d_below, d_ramp;
    logic [ck_pkg::SQ_W-1:0]   c_sq;
    logic [ck_pkg::DIST_W-1:0] s_dist;
    logic [MASK_BITS:0]        d_quot;
    logic [7:0] o_red, o_green, o_blue;

    assign pready = 1'b1;
    assign idx    = ck_pkg::reg_idx_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_red_reg   <= 8'd0;
            key_green_reg <= 8'd255;
            key_blue_reg  <= 8'd0;
            tol_low_reg   <= 9'd40;
            tol_high_reg  <= 9'd80;
        end
        else if (wr)
        begin
            case (idx)
                ck_pkg::REG_KEY_RED:   key_red_reg   <= pwdata[7:0];
                ck_pkg::REG_KEY_GREEN: key_green_reg <= pwdata[7:0];
                ck_pkg::REG_KEY_BLUE:  key_blue_reg  <= pwdata[7:0];
                ck_pkg::REG_TOL_LOW:   tol_low_reg   <= pwdata[8:0];
                ck_pkg::REG_TOL_HIGH:  tol_high_reg  <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            ck_pkg::REG_KEY_RED:   prdata = {24'd0, key_red_reg};
            ck_pkg::REG_KEY_GREEN: prdata = {24'd0, key_green_reg};
            ck_pkg::REG_KEY_BLUE:  prdata = {24'd0, key_blue_reg};
            ck_pkg::REG_TOL_LOW:   prdata = {23'd0, tol_low_reg};
            ck_pkg::REG_TOL_HIGH:  prdata = {23'd0, tol_high_reg};
            default:               prdata = 32'd0;
        endcase
    end

    assign key.red   = key_red_reg;
    assign key.green = key_green_reg;
    assign key.blue  = key_blue_reg;

    assign in_px.fg_red   = s_tdata[7:0];
    assign in_px.fg_green = s_tdata[15:8];
    assign in_px.fg_blue  = s_tdata[23:16];
    assign in_px.bg_red   = s_tdata[31:24];
    assign in_px.bg_green = s_tdata[39:32];
    assign in_px.bg_blue  = s_tdata[47:40];

    // advance every stage when the output slot is free or being taken
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    ck_color u_color (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_px     (in_px),
        .key       (key),
        .out_valid (c_vld),
        .out_px    (c_px),
        .out_sq    (c_sq)
    );

    ck_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (c_vld),
        .in_px     (c_px),
        .in_sq     (c_sq),
        .out_valid (s_vld),
        .out_px    (s_px),
        .out_dist  (s_dist)
    );

    ck_div #(.MASK_BITS(MASK_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_vld),
        .in_px     (s_px),
        .in_dist   (s_dist),
        .tol_low   (tol_low_reg),
        .tol_high  (tol_high_reg),
        .out_valid (d_vld),
        .out_px    (d_px),
        .out_below (d_below),
        .out_ramp  (d_ramp),
        .out_quot  (d_quot)
    );

    ck_blend #(.MASK_BITS(MASK_BITS)) u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d_vld),
        .in_px     (d_px),
        .in_below  (d_below),
        .in_ramp   (d_ramp),
        .in_quot   (d_quot),
        .key       (key),
        .out_valid (m_tvalid),
        .out_red   (o_red),
        .out_green (o_green),
        .out_blue  (o_blue)
    );

    assign m_tdata = {o_blue, o_green, o_red};

endmodule

`default_nettype wire

### rtl/ck_checker.sv
`default_nettype none

module ck_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("output item dropped");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("output item changed while stalled");

endmodule

bind chroma_key_composite ck_checker u_ck_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
